FILE: sv/srpc_pkg.sv
// ----------------------------------------------------------------------------
// srpc_pkg
// Shared types and constants for the scheduled refill pump controller.
// ----------------------------------------------------------------------------
package srpc_pkg;

    localparam int unsigned TICKS_PER_SECOND = 10000;
    localparam int unsigned TPS_W = $clog2(TICKS_PER_SECOND + 1);
    localparam logic [TPS_W-1:0] TPS_V = TPS_W'(TICKS_PER_SECOND);

    // floor(2^32 / T), quotient estimate is low by at most one
    localparam longint unsigned RECIP = (64'd1 << 32) / TICKS_PER_SECOND;
    localparam int unsigned RECIP_W = $clog2(RECIP + 1);

    localparam int unsigned TICK_W = 32;
    localparam int unsigned PROD_W = TICK_W + RECIP_W;
    localparam longint unsigned SEC_MAX =
        (64'hFFFF_FFFF + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
    localparam int unsigned SEC_W = $clog2(SEC_MAX + 1);

    localparam int unsigned HOUR_W = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned MAX_RUN_W = 16;
    localparam int unsigned STOPPED_W = 19;
    localparam int unsigned RUNNING_W = 16;

    localparam logic [MINUTE_W-1:0] START_MINUTE = MINUTE_W'(11);
    localparam logic [MAX_RUN_W-1:0] DEFAULT_MAX_RUN = MAX_RUN_W'(5 * 60);

    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic REG_ENABLED = 1'b0;
    localparam logic REG_MAX_RUN = 1'b1;

    typedef struct packed {
        logic                 enabled;
        logic [MAX_RUN_W-1:0] max_run;
        logic [TICK_W-1:0]    limit_ticks;
    } cfg_t;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld_out;
    } adv_t;

endpackage

FILE: sv/srpc_regs.sv
// ----------------------------------------------------------------------------
// srpc_regs
// APB register file: enable bit and run limit, plus the run limit in ticks.
// ----------------------------------------------------------------------------
module srpc_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [srpc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [srpc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [srpc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output srpc_pkg::cfg_t                       cfg
);

    logic                             enabled_reg;
    logic [srpc_pkg::MAX_RUN_W-1:0]   max_run_reg;
    logic [srpc_pkg::TICK_W-1:0]      limit_reg;
    logic [srpc_pkg::TICK_W-1:0]      limit_next;
    logic [srpc_pkg::MAX_RUN_W+srpc_pkg::TPS_W-1:0] limit_full;
    logic                             wr_en;
    logic                             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[2];

    // limit in ticks tracks the written value on the same edge
    assign limit_full = (srpc_pkg::MAX_RUN_W + srpc_pkg::TPS_W)'(pwdata[srpc_pkg::MAX_RUN_W-1:0])
                      * (srpc_pkg::MAX_RUN_W + srpc_pkg::TPS_W)'(srpc_pkg::TPS_V);
    assign limit_next = srpc_pkg::TICK_W'(limit_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            max_run_reg <= srpc_pkg::DEFAULT_MAX_RUN;
            limit_reg   <= srpc_pkg::TICK_W'(srpc_pkg::DEFAULT_MAX_RUN
                                             * srpc_pkg::TICKS_PER_SECOND);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                srpc_pkg::REG_ENABLED: enabled_reg <= pwdata[0];
                srpc_pkg::REG_MAX_RUN:
                begin
                    max_run_reg <= pwdata[srpc_pkg::MAX_RUN_W-1:0];
                    limit_reg   <= limit_next;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            srpc_pkg::REG_ENABLED: prdata = srpc_pkg::APB_DATA_W'(enabled_reg);
            srpc_pkg::REG_MAX_RUN: prdata = srpc_pkg::APB_DATA_W'(max_run_reg);
            default:               prdata = '0;
        endcase
    end

    assign cfg.enabled     = enabled_reg;
    assign cfg.max_run     = max_run_reg;
    assign cfg.limit_ticks = limit_reg;

endmodule

FILE: sv/srpc_ctrl.sv
// ----------------------------------------------------------------------------
// srpc_ctrl
// Pump start/stop decision, recorded times and the two tick differences.
// ----------------------------------------------------------------------------
module srpc_ctrl
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  srpc_pkg::cfg_t                      cfg,
    input  logic                                commit,
    input  logic [srpc_pkg::HOUR_W-1:0]         hour,
    input  logic [srpc_pkg::MINUTE_W-1:0]       minute,
    input  logic                                tank_full,
    input  logic [srpc_pkg::TICK_W-1:0]         now_ticks,
    output logic                                pump_on,
    output logic [srpc_pkg::TICK_W-1:0]         stop_diff,
    output logic [srpc_pkg::TICK_W-1:0]         run_diff
);

    logic                            running_reg;
    logic                            running_next;
    logic [srpc_pkg::MINUTE_W-1:0]   prev_minute_reg;
    logic [srpc_pkg::MINUTE_W-1:0]   prev_minute_next;
    logic [srpc_pkg::TICK_W-1:0]     start_reg;
    logic [srpc_pkg::TICK_W-1:0]     start_next;
    logic [srpc_pkg::TICK_W-1:0]     stop_reg;
    logic [srpc_pkg::TICK_W-1:0]     stop_next;
    logic [srpc_pkg::TICK_W-1:0]     deadline;
    logic                            timeout;
    logic                            changed;

    assign deadline = start_reg + cfg.limit_ticks;
    assign timeout  = now_ticks > deadline;
    assign changed  = prev_minute_reg != minute;

    always_comb
    begin
        running_next     = running_reg;
        prev_minute_next = prev_minute_reg;
        start_next       = start_reg;
        stop_next        = stop_reg;
        if (cfg.enabled)
        begin
            prev_minute_next = minute;
            if (running_reg)
            begin
                if (tank_full || timeout)
                begin
                    stop_next    = now_ticks;
                    running_next = 1'b0;
                end
            end
            else if (!tank_full && hour[0] && changed && minute == srpc_pkg::START_MINUTE)
            begin
                start_next   = now_ticks;
                running_next = 1'b1;
            end
        end
    end

    assign pump_on   = running_next;
    assign stop_diff = running_next ? (start_next - stop_next) : (now_ticks - stop_next);
    assign run_diff  = running_next ? (now_ticks - start_next) : (stop_next - start_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg     <= 1'b0;
            prev_minute_reg <= '0;
            start_reg       <= '0;
            stop_reg        <= '0;
        end
        else if (commit)
        begin
            running_reg     <= running_next;
            prev_minute_reg <= prev_minute_next;
            start_reg       <= start_next;
            stop_reg        <= stop_next;
        end
    end

endmodule

FILE: sv/srpc_sec_div.sv
// ----------------------------------------------------------------------------
// srpc_sec_div
// Ticks to seconds, rounding up: reciprocal multiply, back-multiply, one
// correction step, then the round-up increment into the result register.
// ----------------------------------------------------------------------------
module srpc_sec_div
(
    input  logic                               clk,
    input  srpc_pkg::adv_t                     adv,
    input  logic [srpc_pkg::TICK_W-1:0]        ticks,
    output logic [srpc_pkg::SEC_W-1:0]         seconds
);

    localparam int unsigned QT_W = srpc_pkg::SEC_W + srpc_pkg::TPS_W;

    logic [srpc_pkg::TICK_W-1:0]   d1_reg;
    logic [srpc_pkg::TICK_W-1:0]   d2_reg;
    logic [srpc_pkg::TICK_W-1:0]   d3_reg;
    logic [srpc_pkg::PROD_W-1:0]   prod_reg;
    logic [srpc_pkg::PROD_W-1:0]   prod_next;
    logic [srpc_pkg::SEC_W-1:0]    q_est;
    logic [srpc_pkg::SEC_W-1:0]    q3_reg;
    logic [QT_W-1:0]               qt_full;
    logic [srpc_pkg::TICK_W-1:0]   qt3_reg;
    logic [srpc_pkg::TICK_W-1:0]   rem0;
    logic [srpc_pkg::TICK_W-1:0]   rem1;
    logic                          over;
    logic [srpc_pkg::SEC_W-1:0]    q_fix;
    logic [srpc_pkg::SEC_W-1:0]    sec_next;
    logic [srpc_pkg::SEC_W-1:0]    sec_reg;

    assign prod_next = srpc_pkg::PROD_W'(d1_reg) * srpc_pkg::PROD_W'(srpc_pkg::RECIP);
    assign q_est     = srpc_pkg::SEC_W'(prod_reg >> srpc_pkg::TICK_W);
    assign qt_full   = QT_W'(q_est) * QT_W'(srpc_pkg::TPS_V);

    assign rem0     = d3_reg - qt3_reg;
    assign over     = rem0 >= srpc_pkg::TICK_W'(srpc_pkg::TPS_V);
    assign rem1     = over ? (rem0 - srpc_pkg::TICK_W'(srpc_pkg::TPS_V)) : rem0;
    assign q_fix    = over ? (q3_reg + srpc_pkg::SEC_W'(1)) : q3_reg;
    assign sec_next = q_fix + srpc_pkg::SEC_W'(rem1 != '0);

    always_ff @(posedge clk)
    begin
        if (adv.ld1)
        begin
            d1_reg <= ticks;
        end
        if (adv.ld2)
        begin
            d2_reg   <= d1_reg;
            prod_reg <= prod_next;
        end
        if (adv.ld3)
        begin
            d3_reg  <= d2_reg;
            q3_reg  <= q_est;
            qt3_reg <= srpc_pkg::TICK_W'(qt_full);
        end
        if (adv.ld_out)
        begin
            sec_reg <= sec_next;
        end
    end

    assign seconds = sec_reg;

endmodule

FILE: sv/scheduled_refill_pump_controller.sv
// ----------------------------------------------------------------------------
// scheduled_refill_pump_controller
// Scheduled refill pump control with run-time limit and duration reporting.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | beat
//  tick    | in        | in_valid/in_stall  | hour, minute, tank_full, now_ticks
//  result  | out       | out_valid/out_stall| pump_on, stopped_seconds,
//          |           |                    | running_seconds
//  config  | in        | APB                | enabled @0x0, max_run_seconds @0x4
//
// One beat per cycle sustained while out_stall is low. A result passes from the
// input register through the v1, v2 and v3 stage registers into the output
// register; depth is set by the two registered multiplies of the tick-to-seconds conversion.
// Reset clears the pump state and all stage valids; no sweep.
// Stalls back up stage by stage; empty stages keep accepting.
// ----------------------------------------------------------------------------
module scheduled_refill_pump_controller
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [srpc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [srpc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [srpc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [srpc_pkg::HOUR_W-1:0]          hour,
    input  logic [srpc_pkg::MINUTE_W-1:0]        minute,
    input  logic                                 tank_full,
    input  logic [srpc_pkg::TICK_W-1:0]          now_ticks,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 pump_on,
    output logic [srpc_pkg::STOPPED_W-1:0]       stopped_seconds,
    output logic [srpc_pkg::RUNNING_W-1:0]       running_seconds
);

    srpc_pkg::cfg_t                  cfg;
    srpc_pkg::adv_t                  adv;

    logic                            va_reg;
    logic                            v1_reg;
    logic                            v2_reg;
    logic                            v3_reg;
    logic                            vo_reg;
    logic                            rdy_a;
    logic                            rdy_1;
    logic                            rdy_2;
    logic                            rdy_3;
    logic                            rdy_o;
    logic                            accept;

    logic [srpc_pkg::HOUR_W-1:0]     hour_reg;
    logic [srpc_pkg::MINUTE_W-1:0]   minute_reg;
    logic                            full_reg;
    logic [srpc_pkg::TICK_W-1:0]     now_reg;

    logic                            pump_a;
    logic [srpc_pkg::TICK_W-1:0]     stop_diff;
    logic [srpc_pkg::TICK_W-1:0]     run_diff;
    logic                            pump1_reg;
    logic                            pump2_reg;
    logic                            pump3_reg;
    logic                            pumpo_reg;
    logic [srpc_pkg::SEC_W-1:0]      stop_sec;
    logic [srpc_pkg::SEC_W-1:0]      run_sec;

    assign rdy_o  = !vo_reg || !out_stall;
    assign rdy_3  = !v3_reg || rdy_o;
    assign rdy_2  = !v2_reg || rdy_3;
    assign rdy_1  = !v1_reg || rdy_2;
    assign rdy_a  = !va_reg || rdy_1;

    assign adv.ld_out = v3_reg && rdy_o;
    assign adv.ld3    = v2_reg && rdy_3;
    assign adv.ld2    = v1_reg && rdy_2;
    assign adv.ld1    = va_reg && rdy_1;

    assign in_stall = !rdy_a;
    assign accept   = in_valid && rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            va_reg <= accept     || (va_reg && !adv.ld1);
            v1_reg <= adv.ld1    || (v1_reg && !adv.ld2);
            v2_reg <= adv.ld2    || (v2_reg && !adv.ld3);
            v3_reg <= adv.ld3    || (v3_reg && !adv.ld_out);
            vo_reg <= adv.ld_out || (vo_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hour_reg   <= hour;
            minute_reg <= minute;
            full_reg   <= tank_full;
            now_reg    <= now_ticks;
        end
        if (adv.ld1)
        begin
            pump1_reg <= pump_a;
        end
        if (adv.ld2)
        begin
            pump2_reg <= pump1_reg;
        end
        if (adv.ld3)
        begin
            pump3_reg <= pump2_reg;
        end
        if (adv.ld_out)
        begin
            pumpo_reg <= pump3_reg;
        end
    end

    srpc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srpc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .commit    (adv.ld1),
        .hour      (hour_reg),
        .minute    (minute_reg),
        .tank_full (full_reg),
        .now_ticks (now_reg),
        .pump_on   (pump_a),
        .stop_diff (stop_diff),
        .run_diff  (run_diff)
    );

    srpc_sec_div u_stop_div
    (
        .clk     (clk),
        .adv     (adv),
        .ticks   (stop_diff),
        .seconds (stop_sec)
    );

    srpc_sec_div u_run_div
    (
        .clk     (clk),
        .adv     (adv),
        .ticks   (run_diff),
        .seconds (run_sec)
    );

    assign out_valid       = vo_reg;
    assign pump_on         = pumpo_reg;
    assign stopped_seconds = srpc_pkg::STOPPED_W'(stop_sec);
    assign running_seconds = srpc_pkg::RUNNING_W'(run_sec);

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the refill pump controller against a cycle-free prediction of the
// pump state and its two duration counters. A short directed table covers
// disabled ticks, start conditions, full-tank and run-limit stops, deadline
// wrap and counter wrap; random scheduled-refill traffic follows under several
// register settings, with random stalls on both channels and a long output
// hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    typedef enum logic [1:0] {ROW_TICK, ROW_SET_ENABLED, ROW_SET_MAX_RUN} row_kind_t;

    typedef struct packed {
        logic                           pump;
        logic [srpc_pkg::STOPPED_W-1:0] stopped_s;
        logic [srpc_pkg::RUNNING_W-1:0] running_s;
    } pump_report_t;

    typedef struct packed {
        row_kind_t                     kind;
        logic [srpc_pkg::HOUR_W-1:0]   hour;
        logic [srpc_pkg::MINUTE_W-1:0] minute;
        logic                          full;
        logic [srpc_pkg::TICK_W-1:0]   word;
        logic                          chk;
        pump_report_t                  exp;
    } dir_row_t;

    localparam logic [srpc_pkg::APB_ADDR_W-1:0] ADDR_ENABLED =
        srpc_pkg::APB_ADDR_W'(4 * srpc_pkg::REG_ENABLED);
    localparam logic [srpc_pkg::APB_ADDR_W-1:0] ADDR_MAX_RUN =
        srpc_pkg::APB_ADDR_W'(4 * srpc_pkg::REG_MAX_RUN);
    localparam pump_report_t NO_EXP = '0;
    localparam int DIR_ROWS = 30;
    localparam int HOLD_CYCLES = 300;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [srpc_pkg::APB_ADDR_W-1:0] paddr;
    logic [srpc_pkg::APB_DATA_W-1:0] pwdata;
    logic [srpc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            in_valid;
    logic                            in_stall;
    logic [srpc_pkg::HOUR_W-1:0]     hour;
    logic [srpc_pkg::MINUTE_W-1:0]   minute;
    logic                            tank_full;
    logic [srpc_pkg::TICK_W-1:0]     now_ticks;
    logic                            out_valid;
    logic                            out_stall;
    logic                            pump_on;
    logic [srpc_pkg::STOPPED_W-1:0]  stopped_seconds;
    logic [srpc_pkg::RUNNING_W-1:0]  running_seconds;

    scheduled_refill_pump_controller dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .hour            (hour),
        .minute          (minute),
        .tank_full       (tank_full),
        .now_ticks       (now_ticks),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pump_on         (pump_on),
        .stopped_seconds (stopped_seconds),
        .running_seconds (running_seconds)
    );

    // predicted controller state and registers
    logic                           en_reg;
    logic [srpc_pkg::MAX_RUN_W-1:0] max_run_reg;
    logic                           pump_is_on;
    logic [srpc_pkg::MINUTE_W-1:0]  prev_min;
    logic [srpc_pkg::TICK_W-1:0]    t_started;
    logic [srpc_pkg::TICK_W-1:0]    t_stopped;

    pump_report_t pending_reports [$];
    int           mismatches;
    logic         typed_valid;
    pump_report_t typed_report;
    logic         quiet;
    int           hold_order;

    dir_row_t plan [DIR_ROWS] = '{
        '{ROW_TICK, 5'd1, 6'd11, 1'b0, 32'h1234_5678, 1'b1, '{1'b0, 19'd30542, 16'd0}},
        '{ROW_TICK, 5'd31, 6'd63, 1'b1, 32'hFFFF_FFFF, 1'b1, '{1'b0, 19'd429497, 16'd0}},
        '{ROW_TICK, 5'd0, 6'd0, 1'b0, 32'd0, 1'b1, '{1'b0, 19'd0, 16'd0}},
        '{ROW_SET_ENABLED, 5'd0, 6'd0, 1'b0, 32'd1, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd1, 6'd11, 1'b0, 32'd1000, 1'b1, '{1'b1, 19'd1, 16'd0}},
        '{ROW_TICK, 5'd1, 6'd11, 1'b0, 32'd3001000, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd1, 6'd11, 1'b0, 32'd3001001, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd2, 6'd10, 1'b0, 32'd3200000, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd2, 6'd11, 1'b0, 32'd3300000, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd3, 6'd10, 1'b0, 32'd3400000, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd3, 6'd11, 1'b1, 32'd3500000, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd3, 6'd60, 1'b0, 32'd3600000, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd23, 6'd11, 1'b0, 32'd5000000, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd0, 6'd63, 1'b1, 32'd5000500, 1'b0, NO_EXP},
        '{ROW_SET_MAX_RUN, 5'd0, 6'd0, 1'b0, 32'd1, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd5, 6'd12, 1'b0, 32'd6000000, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd5, 6'd11, 1'b0, 32'd6000000, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd5, 6'd11, 1'b0, 32'd6010001, 1'b0, NO_EXP},
        '{ROW_SET_MAX_RUN, 5'd0, 6'd0, 1'b0, 32'd65535, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd7, 6'd10, 1'b0, 32'hFFFF_0000, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd7, 6'd11, 1'b0, 32'hFFFF_0000, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd7, 6'd11, 1'b0, 32'hFFFF_0001, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd9, 6'd10, 1'b0, 32'd0, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd9, 6'd11, 1'b0, 32'd0, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd9, 6'd11, 1'b0, 32'd4000000000, 1'b0, NO_EXP},
        '{ROW_SET_ENABLED, 5'd0, 6'd0, 1'b0, 32'd0, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd11, 6'd30, 1'b0, 32'd4000100000, 1'b0, NO_EXP},
        '{ROW_SET_ENABLED, 5'd0, 6'd0, 1'b0, 32'd1, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd11, 6'd11, 1'b0, 32'd4000200000, 1'b0, NO_EXP},
        '{ROW_TICK, 5'd11, 6'd12, 1'b0, 32'd4000300000, 1'b0, NO_EXP}
    };

    function automatic logic [31:0] whole_seconds_up(input logic [srpc_pkg::TICK_W-1:0] d);
        longint unsigned t;
        t = 64'(d) + 64'(srpc_pkg::TICKS_PER_SECOND - 1);
        return 32'(t / srpc_pkg::TICKS_PER_SECOND);
    endfunction

    function automatic pump_report_t next_pump_report(
        input logic [srpc_pkg::HOUR_W-1:0]   h,
        input logic [srpc_pkg::MINUTE_W-1:0] m,
        input logic                          full,
        input logic [srpc_pkg::TICK_W-1:0]   now
    );
        pump_report_t                r;
        logic                        fresh;
        logic [srpc_pkg::TICK_W-1:0] deadline;
        logic [31:0]                 s_stop;
        logic [31:0]                 s_run;
        if (en_reg)
        begin
            fresh = (prev_min != m);
            prev_min = m;
            if (pump_is_on)
            begin
                deadline = t_started
                         + srpc_pkg::TICK_W'(max_run_reg * srpc_pkg::TICKS_PER_SECOND);
                if (full || now > deadline)
                begin
                    t_stopped = now;
                    pump_is_on = 1'b0;
                end
            end
            else if (!full && h[0] && fresh && m == srpc_pkg::START_MINUTE)
            begin
                t_started = now;
                pump_is_on = 1'b1;
            end
        end
        if (pump_is_on)
        begin
            s_stop = whole_seconds_up(t_started - t_stopped);
            s_run = whole_seconds_up(now - t_started);
        end
        else
        begin
            s_stop = whole_seconds_up(now - t_stopped);
            s_run = whole_seconds_up(t_stopped - t_started);
        end
        r.pump = pump_is_on;
        r.stopped_s = s_stop[srpc_pkg::STOPPED_W-1:0];
        r.running_s = s_run[srpc_pkg::RUNNING_W-1:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_order != hold_seen)
            begin
                hold_seen = hold_order;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall = !quiet && ($urandom_range(99) < 34);
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        pump_report_t want;
        pump_report_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                want = next_pump_report(hour, minute, tank_full, now_ticks);
                if (typed_valid)
                begin
                    want = typed_report;
                end
                pending_reports.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                got = '{pump_on, stopped_seconds, running_seconds};
                if (pending_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected beat: pump_on %0d stopped %0d running %0d",
                             $time, got.pump, got.stopped_s, got.running_s);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (got.pump !== want.pump)
                    begin
                        mismatches++;
                        $display("%0t pump_on expected %0d got %0d",
                                 $time, want.pump, got.pump);
                    end
                    if (got.stopped_s !== want.stopped_s)
                    begin
                        mismatches++;
                        $display("%0t stopped_seconds expected %0d got %0d",
                                 $time, want.stopped_s, got.stopped_s);
                    end
                    if (got.running_s !== want.running_s)
                    begin
                        mismatches++;
                        $display("%0t running_seconds expected %0d got %0d",
                                 $time, want.running_s, got.running_s);
                    end
                end
            end
        end
    end

    task automatic drain_reports();
        in_valid = 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [srpc_pkg::APB_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        drain_reports();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr == ADDR_ENABLED)
        begin
            en_reg = data[0];
        end
        else
        begin
            max_run_reg = data[srpc_pkg::MAX_RUN_W-1:0];
        end
    endtask

    task automatic send_tick(
        input logic [srpc_pkg::HOUR_W-1:0]   h,
        input logic [srpc_pkg::MINUTE_W-1:0] m,
        input logic                          f,
        input logic [srpc_pkg::TICK_W-1:0]   t,
        input logic                          chk,
        input pump_report_t                  exp
    );
        while (!quiet && $urandom_range(99) < 34)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        typed_valid = chk;
        typed_report = exp;
        in_valid = 1'b1;
        hour = h;
        minute = m;
        tank_full = f;
        now_ticks = t;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                            phase_en [6];
        int                            phase_max [6];
        int                            phase_len [6];
        int                            roll;
        logic [srpc_pkg::HOUR_W-1:0]   h;
        logic [srpc_pkg::MINUTE_W-1:0] m;
        logic                          f;
        logic [srpc_pkg::TICK_W-1:0]   t;
        logic [srpc_pkg::TICK_W-1:0]   clock_now;
        logic [srpc_pkg::MINUTE_W-1:0] clock_min;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        hour = '0;
        minute = '0;
        tank_full = 1'b0;
        now_ticks = '0;
        typed_valid = 1'b0;
        typed_report = NO_EXP;
        quiet = 1'b0;
        hold_order = 0;
        mismatches = 0;
        en_reg = 1'b0;
        max_run_reg = srpc_pkg::DEFAULT_MAX_RUN;
        pump_is_on = 1'b0;
        prev_min = '0;
        t_started = '0;
        t_stopped = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_SET_ENABLED: write_reg(ADDR_ENABLED, plan[i].word);
                ROW_SET_MAX_RUN: write_reg(ADDR_MAX_RUN, plan[i].word);
                default: send_tick(plan[i].hour, plan[i].minute, plan[i].full,
                                   plan[i].word, plan[i].chk, plan[i].exp);
            endcase
        end
        drain_reports();
        typed_valid = 1'b0;

        phase_en = '{1, 1, 1, 0, 1, 1};
        phase_max = '{300, 1, 65535, int'($urandom_range(65535, 1)),
                      int'($urandom_range(65535, 1)), 2};
        phase_len = '{100, 100, 100, 60, 120, 120};
        clock_now = $urandom;
        clock_min = '0;

        for (int p = 0; p < 6; p++)
        begin
            write_reg(ADDR_ENABLED, 32'(phase_en[p]));
            write_reg(ADDR_MAX_RUN, 32'(phase_max[p]));
            quiet = (p == 1);
            for (int k = 0; k < phase_len[p]; k++)
            begin
                if (p == 2 && k == 10)
                begin
                    hold_order++;
                end
                if (p == 4 && k == 60)
                begin
                    drain_reports();
                end
                roll = $urandom_range(99);
                if (roll < 15)
                begin
                    h = srpc_pkg::HOUR_W'($urandom_range(31));
                    m = srpc_pkg::MINUTE_W'($urandom_range(63));
                    f = 1'($urandom_range(1));
                    t = $urandom;
                end
                else
                begin
                    roll = $urandom_range(99);
                    if (roll < 65)
                    begin
                        clock_now += $urandom_range(50000);
                    end
                    else if (roll < 90)
                    begin
                        clock_now += $urandom_range(2000000);
                    end
                    else
                    begin
                        clock_now += $urandom_range(32'h3FFF_FFFF);
                    end
                    case ($urandom_range(4))
                        0: clock_min = 6'd10;
                        1, 2: clock_min = srpc_pkg::START_MINUTE;
                        3: clock_min = 6'd12;
                        default: ;
                    endcase
                    m = clock_min;
                    h = srpc_pkg::HOUR_W'($urandom_range(31));
                    if ($urandom_range(99) < 80)
                    begin
                        h[0] = 1'b1;
                    end
                    f = pump_is_on ? ($urandom_range(99) < 8) : ($urandom_range(99) < 15);
                    t = clock_now;
                end
                send_tick(h, m, f, t, 1'b0, NO_EXP);
            end
        end
        quiet = 1'b0;
        drain_reports();

        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/srpc_pkg.sv
sv/srpc_regs.sv
sv/srpc_ctrl.sv
sv/srpc_sec_div.sv
sv/scheduled_refill_pump_controller.sv
test/tb_top.sv
